@@ sv/rsort_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsort_pkg
// Shared types for the score sorter: the stored record and the cell controls.
// ----------------------------------------------------------------------------
package rsort_pkg;

    localparam int SCORE_W = 16;
    localparam int ID_W    = 8;

    // one stored rating record
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [ID_W-1:0]    group_id;
        logic [ID_W-1:0]    evaluator_id;
    } record_t;

    // controls broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // place the incoming record
        logic shift;  // move every record one cell toward the head
    } cell_ctl_t;

endpackage

@@ sv/rsort_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsort_if
// Valid/ready channels for incoming records and sorted results.
// ----------------------------------------------------------------------------
interface rsort_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] score;
    logic [7:0]  group_id;
    logic [7:0]  evaluator_id;
    logic        last_in;

    modport source (output valid, score, group_id, evaluator_id, last_in, input ready);
    modport sink   (input valid, score, group_id, evaluator_id, last_in, output ready);
endinterface

interface rsort_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] sorted_score;
    logic [7:0]  sorted_group;
    logic [7:0]  sorted_evaluator;
    logic        last_out;
    logic        dropped;

    modport source (output valid, sorted_score, sorted_group, sorted_evaluator,
                    last_out, dropped, input ready);
    modport sink   (input valid, sorted_score, sorted_group, sorted_evaluator,
                    last_out, dropped, output ready);
endinterface

@@ sv/rsort_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsort_cell
// One slot of the insertion chain: holds a record and its valid flag.
// ----------------------------------------------------------------------------
module rsort_cell
    import rsort_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  record_t   new_rec,
    input  record_t   left_rec,
    input  logic      left_valid,
    input  logic      left_gt,
    input  record_t   right_rec,
    input  logic      right_valid,
    output record_t   rec,
    output logic      valid,
    output logic      gt
);

    record_t rec_reg, rec_next;
    logic    valid_reg, valid_next;

    // empty slots count as greater so the record lands after all valid ones
    assign gt = !valid_reg || (rec_reg.score > new_rec.score);

    // insert takes the new record or the left neighbor's, drain takes the right
    always_comb
    begin
        rec_next   = rec_reg;
        valid_next = valid_reg;
        if (ctl.load && gt)
        begin
            if (left_gt)
            begin
                rec_next   = left_rec;
                valid_next = left_valid;
            end
            else
            begin
                rec_next   = new_rec;
                valid_next = 1'b1;
            end
        end
        else if (ctl.shift)
        begin
            rec_next   = right_rec;
            valid_next = right_valid;
        end
    end

    // record payload
    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign rec   = rec_reg;
    assign valid = valid_reg;

endmodule

@@ sv/record_sort_by_score.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_sort_by_score
// Stable insertion sorter for rating records, built as a chain of cells.
// ----------------------------------------------------------------------------
// Records are loaded at one per cycle while the input is ready: every cell
// compares its score with the incoming one in the same cycle and the record
// drops into place, with equal scores kept in arrival order. The transfer
// that carries last_in ends the batch; from the next cycle the chain drains
// from its head, one sorted record per cycle while the output is ready, and
// the input stays not ready. Records arriving at a full chain of CAPACITY
// cells are dropped and every result of that batch carries dropped.
module record_sort_by_score
    import rsort_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    rsort_in_if.sink    in_ch,
    rsort_out_if.source out_ch
);

    record_t   cell_rec   [CAPACITY];
    logic      cell_valid [CAPACITY];
    logic      cell_gt    [CAPACITY];
    record_t   new_rec;
    cell_ctl_t ctl;
    logic      in_xfer;
    logic      out_xfer;
    logic      full;
    logic      drain_reg, drain_next;
    logic      overflow_reg, overflow_next;

    // input side
    assign new_rec.score        = in_ch.score;
    assign new_rec.group_id     = in_ch.group_id;
    assign new_rec.evaluator_id = in_ch.evaluator_id;
    assign in_ch.ready = !drain_reg;
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_xfer    = out_ch.valid && out_ch.ready;
    assign full        = cell_valid[CAPACITY-1];

    assign ctl.load  = in_xfer && !full;
    assign ctl.shift = out_xfer;

    // chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        record_t l_rec, r_rec;
        logic    l_valid, l_gt, r_valid;

        if (i == 0)
        begin : g_head
            assign l_rec   = new_rec;
            assign l_valid = 1'b0;
            assign l_gt    = 1'b0;
        end
        else
        begin : g_body
            assign l_rec   = cell_rec[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_gt    = cell_gt[i-1];
        end

        if (i == CAPACITY-1)
        begin : g_tail
            assign r_rec   = cell_rec[i];
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid
            assign r_rec   = cell_rec[i+1];
            assign r_valid = cell_valid[i+1];
        end

        rsort_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_rec     (new_rec),
            .left_rec    (l_rec),
            .left_valid  (l_valid),
            .left_gt     (l_gt),
            .right_rec   (r_rec),
            .right_valid (r_valid),
            .rec         (cell_rec[i]),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i])
        );
    end

    // batch control: flag overflow on a full input, drain after last_in, clear both at end of run
    always_comb
    begin
        drain_next    = drain_reg;
        overflow_next = overflow_reg;
        if (in_xfer)
        begin
            if (full)
                overflow_next = 1'b1;
            if (in_ch.last_in)
                drain_next = 1'b1;
        end
        if (out_xfer && out_ch.last_out)
        begin
            drain_next    = 1'b0;
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg    <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            drain_reg    <= drain_next;
            overflow_reg <= overflow_next;
        end
    end

    // output side reads the head cell
    assign out_ch.valid            = drain_reg;
    assign out_ch.sorted_score     = cell_rec[0].score;
    assign out_ch.sorted_group     = cell_rec[0].group_id;
    assign out_ch.sorted_evaluator = cell_rec[0].evaluator_id;
    assign out_ch.last_out         = !cell_valid[1];
    assign out_ch.dropped          = overflow_reg;

endmodule

@@ sv/rsort_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsort_checker
// Port-level checks on the score sorter, bound to the top level.
// ----------------------------------------------------------------------------
module rsort_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready,
    input logic out_last,
    input logic out_dropped,
    input logic [15:0] out_score
);

    // no input transfer is taken while a run is being emitted
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready during output run");

    // a final record starts a run in the next cycle
    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> out_valid)
        else $error("no output after last record");

    // the run ends after the transfer flagged last
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> !out_valid)
        else $error("output continues past last record");

    // scores come out in non-decreasing order within a run, and dropped holds steady
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) |=>
            (out_valid && out_score >= $past(out_score) && out_dropped == $past(out_dropped)))
        else $error("run out of order or dropped flag changed");

endmodule

bind record_sort_by_score rsort_checker u_rsort_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_last     (in_ch.last_in),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_last    (out_ch.last_out),
    .out_dropped (out_ch.dropped),
    .out_score   (out_ch.sorted_score)
);
